// ----- design/sha1s_pkg.sv -----
`timescale 1ns / 1ps

package sha1s_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  localparam int RoundCount = 80;
  localparam int BlockBytes = 64;
  localparam int LenPos = 56;
  localparam int DigestWords = 5;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word 0 sits in the lowest slice.
  localparam chain_t INIT_H = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINAL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] new_byte;
    logic       start;
  } core_ctl_t;

  typedef struct packed {
    logic running;
    logic done;
  } core_sts_t;

  function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ----- design/sha1s_core.sv -----
`timescale 1ns / 1ps

module sha1s_core (
  input  logic                clk,
  input  logic                rst,
  input  sha1s_pkg::core_ctl_t ctl,
  input  sha1s_pkg::chain_t   chain_in,
  output sha1s_pkg::chain_t   work,
  output sha1s_pkg::core_sts_t sts
);
  import sha1s_pkg::*;

  localparam logic [6:0] LastRound = 7'(RoundCount - 1);

  // The message block doubles as the schedule window: bytes shift in at the
  // bottom while absorbing, and each round shifts one schedule word in.
  logic [511:0] msg_block;
  logic [6:0]   rnd;
  logic         running;
  logic         done;

  word_t win0, win2, win8, win13;
  word_t w_mix, w, f, k, tmp;
  word_t a, b, c, d, e;
  chain_t work_next;

  assign win0  = msg_block[511:480];
  assign win2  = msg_block[447:416];
  assign win8  = msg_block[255:224];
  assign win13 = msg_block[95:64];

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];
  assign e = work[4];

  always_comb begin
    w_mix = win13 ^ win8 ^ win2 ^ win0;
    w     = (rnd < 7'd16) ? win0 : {w_mix[30:0], w_mix[31]};
    f     = round_f(rnd, b, c, d);
    k     = round_k(rnd);
    tmp   = {a[26:0], a[31:27]} + f + e + k + w;
    work_next[0] = tmp;
    work_next[1] = a;
    work_next[2] = {b[1:0], b[31:2]};
    work_next[3] = c;
    work_next[4] = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        if (rnd == LastRound) begin
          running <= 1'b0;
          done    <= 1'b1;
          rnd     <= '0;
        end else begin
          rnd <= rnd + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work <= chain_in;
    end else if (running) begin
      work <= work_next;
    end
    if (ctl.shift_byte) begin
      msg_block <= {msg_block[503:0], ctl.new_byte};
    end else if (running) begin
      msg_block <= {msg_block[479:0], w};
    end
  end

  assign sts.running = running;
  assign sts.done    = done;

  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    running |-> rnd <= LastRound)
    else $error("round counter beyond the last round");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running) && $past(rnd) == LastRound)
    else $error("compression finished without running its last round");

  a_no_clash: assert property (@(posedge clk) disable iff (rst)
    (ctl.start || ctl.shift_byte) |-> !running)
    else $error("block buffer touched while a compression runs");

endmodule

// ----- design/sha1_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// Absorb request: the 64th byte of a block starts an 80-round compression
// on the shared round unit, with in_ready low until it finishes.
// Finalize request: padding and length bytes shift in up to the block end,
// one or two compressions, then five digest words at one a cycle while out_ready is high.
// Synchronous active-high reset loads the SHA-1 initial values and clears the
// byte count, bit length and overflow flag; the digest output also does this.
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        overflow
);
  import sha1s_pkg::*;

  localparam logic [6:0] LastByte = 7'(BlockBytes - 1);
  localparam logic [6:0] LenByte  = 7'(LenPos);
  localparam logic [2:0] LastWord = 3'(DigestWords - 1);

  state_t      state, state_next;
  logic [6:0]  buf_count, buf_count_next;
  logic [60:0] byte_count, byte_count_next;
  logic        ovf, ovf_next;
  logic        finishing, finishing_next;
  logic        extra, extra_next;
  logic [2:0]  idx, idx_next;
  chain_t      chain, chain_next;

  core_ctl_t   ctl;
  core_sts_t   sts;
  chain_t      work;

  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic [7:0]  pad_byte;

  sha1s_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .chain_in (chain),
    .work     (work),
    .sts      (sts)
  );

  // Length bytes go out most significant first, from byte 56 to byte 63.
  assign len_bits = {byte_count, 3'b000};
  assign len_sel  = 3'd7 - buf_count[2:0];
  assign pad_byte = (extra || buf_count < LenByte) ? 8'h00 : len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    state_next      = state;
    buf_count_next  = buf_count;
    byte_count_next = byte_count;
    ovf_next        = ovf;
    finishing_next  = finishing;
    extra_next      = extra;
    idx_next        = idx;
    chain_next      = chain;
    ctl             = '0;
    in_ready        = 1'b0;
    out_valid       = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OP_ABSORB) begin
            if (&byte_count) begin
              // The bit length would pass 2^64 - 1: drop the byte.
              ovf_next = 1'b1;
            end else begin
              ctl.shift_byte  = 1'b1;
              ctl.new_byte    = data_byte;
              byte_count_next = byte_count + 61'd1;
              if (buf_count == LastByte) begin
                buf_count_next = '0;
                ctl.start      = 1'b1;
                state_next     = S_ROUND;
              end else begin
                buf_count_next = buf_count + 7'd1;
              end
            end
          end else begin
            ctl.shift_byte = 1'b1;
            ctl.new_byte   = PAD_BYTE;
            finishing_next = 1'b1;
            extra_next     = (buf_count >= LenByte);
            if (buf_count == LastByte) begin
              buf_count_next = '0;
              ctl.start      = 1'b1;
              state_next     = S_ROUND;
            end else begin
              buf_count_next = buf_count + 7'd1;
              state_next     = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.new_byte   = pad_byte;
        if (buf_count == LastByte) begin
          buf_count_next = '0;
          ctl.start      = 1'b1;
          state_next     = S_ROUND;
        end else begin
          buf_count_next = buf_count + 7'd1;
        end
      end
      S_ROUND: begin
        if (sts.done) begin
          for (int i = 0; i < DigestWords; i++) begin
            chain_next[i] = chain[i] + work[i];
          end
          priority if (!finishing) begin
            state_next = S_IDLE;
          end else if (extra) begin
            // The length did not fit; one more block of zeros and length.
            extra_next = 1'b0;
            state_next = S_PAD;
          end else begin
            idx_next   = '0;
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx == LastWord) begin
            chain_next      = INIT_H;
            buf_count_next  = '0;
            byte_count_next = '0;
            ovf_next        = 1'b0;
            finishing_next  = 1'b0;
            extra_next      = 1'b0;
            idx_next        = '0;
            state_next      = S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      buf_count  <= '0;
      byte_count <= '0;
      ovf        <= 1'b0;
      finishing  <= 1'b0;
      extra      <= 1'b0;
      idx        <= '0;
      chain      <= INIT_H;
    end else begin
      state      <= state_next;
      buf_count  <= buf_count_next;
      byte_count <= byte_count_next;
      ovf        <= ovf_next;
      finishing  <= finishing_next;
      extra      <= extra_next;
      idx        <= idx_next;
      chain      <= chain_next;
    end
  end

  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = (idx == LastWord);
  assign overflow    = ovf;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx <= LastWord)
    else $error("digest word index out of range");

  a_done_in_round: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> state == S_ROUND)
    else $error("compression finished outside the round state");

  a_round_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> state == S_ROUND && sts.running)
    else $error("compression start not followed by running rounds");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    buf_count <= LastByte)
    else $error("block byte count past the end of the block");

endmodule

// ----- tb/tb_sha1_byte_stream_hasher.sv -----
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher;
  import sha1s_pkg::*;

  localparam int          STALL_LIMIT    = 2000;
  localparam int          DRAIN_CYCLES   = 120;
  localparam int          RANDOM_ITEMS   = 170;
  localparam logic [159:0] SHA1_IV       = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                            32'h10325476, 32'hC3D2E1F0};
  localparam logic [63:0] LENGTH_CEILING = 64'hFFFF_FFFF_FFFF_FFF8;

  typedef struct {
    op_t        op;
    logic [7:0] value;
  } hash_request_t;

  typedef struct {
    word_t      word;
    logic [2:0] position;
    logic       last;
    logic       ovf;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        overflow;

  hash_request_t pending_requests[$];
  hash_request_t next_request;
  digest_beat_t  expected_digest[$];
  digest_beat_t  head_beat;

  // Independent SHA-1 state, advanced once per accepted request.
  word_t       hash_h[5];
  logic [7:0]  msg_block[64];
  int unsigned fill_count;
  logic [63:0] msg_bits;
  logic        len_overflow;

  int  accepted_requests;
  int  mismatches;
  int  idle_cycles;
  int  random_items;
  logic calm;

  sha1_byte_stream_hasher u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .overflow    (overflow)
  );

  always #5 clk = ~clk;

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_reinit();
    for (int i = 0; i < 5; i++) begin
      hash_h[i] = SHA1_IV[159 - 32 * i -: 32];
    end
    fill_count   = 0;
    msg_bits     = '0;
    len_overflow = 1'b0;
  endtask

  task automatic sha1_compress();
    word_t w[16];
    word_t a, b, c, d, e, f, k, wt, sum;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4 * i], msg_block[4 * i + 1], msg_block[4 * i + 2],
              msg_block[4 * i + 3]};
    end
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      sum = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endtask

  task automatic sha1_absorb(input logic [7:0] value);
    // A byte that would carry the bit length past its 64-bit range is dropped.
    if (msg_bits == LENGTH_CEILING) begin
      len_overflow = 1'b1;
    end else begin
      msg_bits += 64'd8;
      msg_block[fill_count] = value;
      fill_count++;
      if (fill_count == 64) begin
        sha1_compress();
        fill_count = 0;
      end
    end
  endtask

  task automatic sha1_finalize();
    digest_beat_t beat;
    msg_block[fill_count] = 8'h80;
    fill_count++;
    // No room for the length field: pad out and compress an extra block.
    if (fill_count > 56) begin
      while (fill_count < 64) begin
        msg_block[fill_count] = 8'h00;
        fill_count++;
      end
      sha1_compress();
      fill_count = 0;
    end
    while (fill_count < 56) begin
      msg_block[fill_count] = 8'h00;
      fill_count++;
    end
    for (int i = 0; i < 8; i++) begin
      msg_block[56 + i] = msg_bits[63 - 8 * i -: 8];
    end
    sha1_compress();
    for (int i = 0; i < 5; i++) begin
      beat.word     = hash_h[i];
      beat.position = 3'(i);
      beat.last     = (i == 4);
      beat.ovf      = len_overflow;
      expected_digest.push_back(beat);
    end
    sha1_reinit();
  endtask

  task automatic queue_request(input op_t op, input logic [7:0] value);
    hash_request_t req;
    req.op    = op;
    req.value = value;
    pending_requests.push_back(req);
  endtask

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) begin
      queue_request(OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    queue_request(OP_FINAL, 8'($urandom_range(0, 255)));
    random_items += len + 1;
  endtask

  function automatic int pick_length();
    int sel;
    int lengths[8];
    sel = $urandom_range(0, 9);
    // Lengths either side of the point where the length field stops fitting.
    lengths = '{54, 55, 56, 57, 62, 63, 64, 65};
    if (sel < 6) begin
      return $urandom_range(0, 12);
    end else if (sel < 9) begin
      return lengths[$urandom_range(0, 7)];
    end
    return $urandom_range(0, 140);
  endfunction

  // A long stretch in the middle of the run with no idling on either side.
  assign calm = (accepted_requests >= 60) && (accepted_requests < 130);

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_requests++;
        if (operation == OP_FINAL) begin
          sha1_finalize();
        end else begin
          sha1_absorb(data_byte);
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          next_request = pending_requests.pop_front();
          in_valid  <= 1'b1;
          operation <= next_request.op;
          data_byte <= next_request.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_digest.size() == 0) begin
        $error("digest_word %h arrived with no digest outstanding", digest_word);
        mismatches++;
      end else begin
        head_beat = expected_digest.pop_front();
        if (digest_word !== head_beat.word) begin
          $error("digest_word: expected %h, got %h", head_beat.word, digest_word);
          mismatches++;
        end
        if (word_index !== head_beat.position) begin
          $error("word_index: expected %0d, got %0d", head_beat.position, word_index);
          mismatches++;
        end
        if (last_word !== head_beat.last) begin
          $error("last_word: expected %b, got %b", head_beat.last, last_word);
          mismatches++;
        end
        if (overflow !== head_beat.ovf) begin
          $error("overflow: expected %b, got %b", head_beat.ovf, overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("sha1_byte_stream_hasher regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int msg_len;
    clk               = 1'b0;
    rst               = 1'b1;
    in_valid          = 1'b0;
    operation         = 1'b0;
    data_byte         = 8'h00;
    out_ready         = 1'b0;
    accepted_requests = 0;
    mismatches        = 0;
    idle_cycles       = 0;
    random_items      = 0;
    sha1_reinit();
    for (int i = 0; i < 64; i++) begin
      msg_block[i] = 8'h00;
    end

    // Empty message, then the classic three-byte message.
    queue_request(OP_FINAL, 8'hA5);
    queue_request(OP_ABSORB, 8'h61);
    queue_request(OP_ABSORB, 8'h62);
    queue_request(OP_ABSORB, 8'h63);
    queue_request(OP_FINAL, 8'h00);
    // Extreme byte values, then a second empty message to check the restart.
    queue_request(OP_ABSORB, 8'h00);
    queue_request(OP_ABSORB, 8'hFF);
    queue_request(OP_ABSORB, 8'h80);
    queue_request(OP_ABSORB, 8'h7F);
    queue_request(OP_FINAL, 8'hFF);
    queue_request(OP_FINAL, 8'h00);

    while (random_items < RANDOM_ITEMS) begin
      msg_len = pick_length();
      // The last message is trimmed so the run stays near its item budget.
      if (msg_len > RANDOM_ITEMS - random_items) begin
        msg_len = RANDOM_ITEMS - random_items;
      end
      queue_message(msg_len);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_digest.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("sha1_byte_stream_hasher regression: pass");
    end else begin
      $display("sha1_byte_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sha1s_pkg.sv
design/sha1s_core.sv
design/sha1_byte_stream_hasher.sv
tb/tb_sha1_byte_stream_hasher.sv
